/* sv/dual_axis_window_stats_defines.svh */
// assertion macros shared by the checker of dual_axis_window_stats
`ifndef DUAL_AXIS_WINDOW_STATS_DEFINES_SVH
`define DUAL_AXIS_WINDOW_STATS_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define DWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dws_pkg.sv */
// command and status types shared by the window statistics controller and datapath
package dws_pkg;

    typedef struct packed {
        logic clr_wr;   // write zero into both windows at the sweep index
        logic load;     // take the input beat, read the oldest entry
        logic update;   // update sums, write the new sample
        logic scan_rd;  // read both windows at the sweep index
        logic out_load; // move the statistics into the output register
    } t_cmd;

    typedef struct packed {
        logic out_busy; // output register full and stalled
    } t_stat;

endpackage

/* sv/dual_axis_window_stats.sv */
// Two-axis sliding-window statistics: centered sample, mean, minimum and maximum per axis.
// Input channel: i_in_valid / o_in_stall carry one beat of i_raw_x and i_raw_y; a beat is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result beat per input beat; the
// result is taken at a rising edge with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data into the center offset; write only when idle.
// Each input beat passes through these steps in order: read the oldest entry, update the sums
// and write the new sample, scan every window entry through the single read port of each
// window memory, drain the scan pipeline and load the output register. The scan of the
// window memories sets the rate. The result appears in the cycle after that load;
// o_in_stall drops again in the same cycle, so a new beat can enter while the previous
// result still waits for the receiver.
// After reset a clearing sweep writes zero into both windows, one entry a cycle;
// o_in_stall stays high meanwhile.
// If the receiver stalls, the result holds and the next beat finishes its scan, then waits
// until the output register is free.
module dual_axis_window_stats #(
    parameter int WINDOW_LOG2 = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [SAMPLE_BITS-1:0]      i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [SAMPLE_BITS-1:0]      i_raw_x,
    input  logic [SAMPLE_BITS-1:0]      i_raw_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_BITS:0] o_x_centered,
    output logic signed [SAMPLE_BITS:0] o_x_mean,
    output logic signed [SAMPLE_BITS:0] o_x_low,
    output logic signed [SAMPLE_BITS:0] o_x_high,
    output logic signed [SAMPLE_BITS:0] o_y_centered,
    output logic signed [SAMPLE_BITS:0] o_y_mean,
    output logic signed [SAMPLE_BITS:0] o_y_low,
    output logic signed [SAMPLE_BITS:0] o_y_high,
    output logic                        o_stats_valid
);

    dws_pkg::t_cmd          w_cmd;
    dws_pkg::t_stat         w_stat;
    logic [WINDOW_LOG2-1:0] w_idx;

    dws_ctrl #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    dws_datapath #(
        .WINDOW_LOG2 (WINDOW_LOG2),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_x_centered  (o_x_centered),
        .o_x_mean      (o_x_mean),
        .o_x_low       (o_x_low),
        .o_x_high      (o_x_high),
        .o_y_centered  (o_y_centered),
        .o_y_mean      (o_y_mean),
        .o_y_low       (o_y_low),
        .o_y_high      (o_y_high),
        .o_stats_valid (o_stats_valid)
    );

endmodule

/* sv/dws_ctrl.sv */
// controller state machine: clearing sweep, sample update, window scan, output handoff
module dws_ctrl #(
    parameter int WINDOW_LOG2 = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  dws_pkg::t_stat         i_stat,
    output dws_pkg::t_cmd          o_cmd,
    output logic [WINDOW_LOG2-1:0] o_idx
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    localparam logic [WINDOW_LOG2-1:0] IDX_LAST = '1;

    t_state                 r_state;
    logic [WINDOW_LOG2-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = r_idx;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_wr   = (r_state == S_CLEAR);
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.scan_rd  = (r_state == S_SCAN);
        o_cmd.out_load = (r_state == S_OUT) && !i_stat.out_busy;
    end

endmodule

/* sv/dws_datapath.sv */
// datapath: offset register, two window memories, running sums, min/max scan, output register
module dws_datapath #(
    parameter int WINDOW_LOG2 = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dws_pkg::t_cmd                 i_cmd,
    input  logic [WINDOW_LOG2-1:0]        i_idx,
    output dws_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [SAMPLE_BITS-1:0]        i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]        i_raw_x,
    input  logic [SAMPLE_BITS-1:0]        i_raw_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS:0]   o_x_centered,
    output logic signed [SAMPLE_BITS:0]   o_x_mean,
    output logic signed [SAMPLE_BITS:0]   o_x_low,
    output logic signed [SAMPLE_BITS:0]   o_x_high,
    output logic signed [SAMPLE_BITS:0]   o_y_centered,
    output logic signed [SAMPLE_BITS:0]   o_y_mean,
    output logic signed [SAMPLE_BITS:0]   o_y_low,
    output logic signed [SAMPLE_BITS:0]   o_y_high,
    output logic                          o_stats_valid
);

    localparam int DEPTH = 1 << WINDOW_LOG2;
    localparam int CW    = SAMPLE_BITS + 1;
    localparam int SW    = SAMPLE_BITS + 1 + WINDOW_LOG2;
    localparam int NW    = WINDOW_LOG2 + 2;

    localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
    localparam logic [NW-1:0]          COUNT_FULL   = NW'(2 * DEPTH);
    localparam logic signed [SW-1:0]   ROUND_NEG    = SW'(DEPTH - 1);

    logic signed [CW-1:0] mem_x [DEPTH];
    logic signed [CW-1:0] mem_y [DEPTH];

    logic [SAMPLE_BITS-1:0] r_offset;
    logic [WINDOW_LOG2-1:0] r_slot;
    logic [NW-1:0]          r_count;
    logic                   r_valid_flag;
    logic signed [CW-1:0]   r_cx;
    logic signed [CW-1:0]   r_cy;
    logic signed [CW-1:0]   r_rd_x;
    logic signed [CW-1:0]   r_rd_y;
    logic                   r_cmp_en;
    logic signed [SW-1:0]   r_sum_x;
    logic signed [SW-1:0]   r_sum_y;
    logic signed [CW-1:0]   r_lo_x;
    logic signed [CW-1:0]   r_hi_x;
    logic signed [CW-1:0]   r_lo_y;
    logic signed [CW-1:0]   r_hi_y;
    logic                   r_out_valid;

    logic [NW-1:0]          n_count;
    logic                   w_we;
    logic                   w_re;
    logic [WINDOW_LOG2-1:0] w_waddr;
    logic [WINDOW_LOG2-1:0] w_raddr;
    logic signed [CW-1:0]   w_wx;
    logic signed [CW-1:0]   w_wy;
    logic signed [SW-1:0]   w_adj_x;
    logic signed [SW-1:0]   w_adj_y;
    logic signed [SW-1:0]   w_div_x;
    logic signed [SW-1:0]   w_div_y;

    // memory port selection
    assign w_we    = i_cmd.clr_wr | i_cmd.update;
    assign w_waddr = i_cmd.clr_wr ? i_idx : r_slot;
    assign w_wx    = i_cmd.clr_wr ? '0 : r_cx;
    assign w_wy    = i_cmd.clr_wr ? '0 : r_cy;
    assign w_re    = i_cmd.load | i_cmd.scan_rd;
    assign w_raddr = i_cmd.load ? r_slot : i_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[w_waddr] <= w_wx;
            mem_y[w_waddr] <= w_wy;
        end
        if (w_re) begin
            r_rd_x <= mem_x[w_raddr];
            r_rd_y <= mem_y[w_raddr];
        end
    end

    assign n_count = (r_count < COUNT_FULL) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= CENTER_RESET;
            r_slot       <= '0;
            r_count      <= '0;
            r_valid_flag <= 1'b0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_cmp_en     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            r_cmp_en <= i_cmd.scan_rd;
            if (i_cmd.update) begin
                r_sum_x      <= r_sum_x - SW'(r_rd_x) + SW'(r_cx);
                r_sum_y      <= r_sum_y - SW'(r_rd_y) + SW'(r_cy);
                r_slot       <= r_slot + 1'b1;
                r_count      <= n_count;
                r_valid_flag <= r_valid_flag | (n_count == COUNT_FULL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= $signed({1'b0, i_raw_x}) - $signed({1'b0, r_offset});
            r_cy <= $signed({1'b0, i_raw_y}) - $signed({1'b0, r_offset});
        end
        // the new sample is in the window, so it seeds the scan
        if (i_cmd.update) begin
            r_lo_x <= r_cx;
            r_hi_x <= r_cx;
            r_lo_y <= r_cy;
            r_hi_y <= r_cy;
        end else if (r_cmp_en) begin
            if (r_rd_x < r_lo_x) r_lo_x <= r_rd_x;
            if (r_rd_x > r_hi_x) r_hi_x <= r_rd_x;
            if (r_rd_y < r_lo_y) r_lo_y <= r_rd_y;
            if (r_rd_y > r_hi_y) r_hi_y <= r_rd_y;
        end
    end

    // divide by window size toward zero: bias negative sums before the shift
    assign w_adj_x = r_sum_x + (r_sum_x[SW-1] ? ROUND_NEG : '0);
    assign w_adj_y = r_sum_y + (r_sum_y[SW-1] ? ROUND_NEG : '0);
    assign w_div_x = w_adj_x >>> WINDOW_LOG2;
    assign w_div_y = w_adj_y >>> WINDOW_LOG2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_x_centered  <= r_cx;
            o_x_mean      <= w_div_x[CW-1:0];
            o_x_low       <= r_lo_x;
            o_x_high      <= r_hi_x;
            o_y_centered  <= r_cy;
            o_y_mean      <= w_div_y[CW-1:0];
            o_y_low       <= r_lo_y;
            o_y_high      <= r_hi_y;
            o_stats_valid <= r_valid_flag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_busy = r_out_valid & i_out_stall;

endmodule

/* sv/dws_checker.sv */
// port-level checker for dual_axis_window_stats and its bind
`include "dual_axis_window_stats_defines.svh"

module dws_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [SAMPLE_BITS:0] o_x_centered,
    input logic signed [SAMPLE_BITS:0] o_x_mean,
    input logic signed [SAMPLE_BITS:0] o_x_low,
    input logic signed [SAMPLE_BITS:0] o_x_high,
    input logic signed [SAMPLE_BITS:0] o_y_centered,
    input logic signed [SAMPLE_BITS:0] o_y_mean,
    input logic signed [SAMPLE_BITS:0] o_y_low,
    input logic signed [SAMPLE_BITS:0] o_y_high,
    input logic                        o_stats_valid
);

    logic w_in_beat;
    logic w_out_hold;
    logic w_x_order;
    logic w_y_order;

    assign w_in_beat  = i_in_valid & !o_in_stall;
    assign w_out_hold = o_out_valid & i_out_stall;
    // the new sample is part of the window, so it lies between low and high
    assign w_x_order  = (o_x_low <= o_x_centered) && (o_x_centered <= o_x_high);
    assign w_y_order  = (o_y_low <= o_y_centered) && (o_y_centered <= o_y_high);

    // one beat at a time: a taken beat closes the input until its result is loaded into the output register
    `DWS_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, o_in_stall,
        "input open after beat")

    // a held result keeps its valid, its means and its stats-valid flag
    `DWS_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, w_out_hold,
        o_out_valid && $stable(o_x_mean) && $stable(o_y_mean) && $stable(o_stats_valid),
        "held result changed")

    `DWS_ASSERT_NOW(a_min_max_order, i_clk, i_rst_n, o_out_valid, w_x_order && w_y_order,
        "window min/max out of order")

    // a result only comes out of a cycle in which the input was closed
    `DWS_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall),
        "result without work")

endmodule

bind dual_axis_window_stats dws_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dws_checker (.*);
